FILE: rtl/core/swsd_pkg.sv
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared types and constants of the sliding window deviation block.
// ----------------------------------------------------------------------------
package swsd_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int DEV_W          = 32;
    localparam int WIN_W          = 7;
    localparam int WIN_MIN        = 2;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL,
        S_SUB,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/swsd_ram.sv
// ----------------------------------------------------------------------------
// swsd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sliding_window_std_dev_top.sv
// ----------------------------------------------------------------------------
// sliding_window_std_dev_top
// Sample standard deviation (ddof=1) of the last W signed Q16.16 samples,
// result unsigned Q16.16, floor(sqrt((W*sum_sq - sum^2) / (W*(W-1)))).
// Samples go into a ring RAM; for each sample the block reads the last W
// entries back one per cycle, squares and accumulates them, forms the
// numerator with a few registered multiplies, divides two quotient bits per
// cycle and takes the integer root one result bit per cycle. One word is
// worked on at a time: a word with a full window passes through the RAM
// pass, the multiplies, the divider and the root before output; a word
// whose series holds fewer than W samples goes straight to output and
// gives deviation 0 with tuser 0.
// The window register is clamped to 2..MAX_WINDOW and sampled per word.
// ----------------------------------------------------------------------------
module sliding_window_std_dev_top
    import swsd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: window_length
    input  logic                i_cfg_we,
    input  logic [WIN_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [SAMPLE_W-1:0] i_s_axis_tdata,   // [31:0] sample
    input  logic                i_s_axis_tuser,   // [0] series_start
    // output stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DEV_W-1:0]    o_m_axis_tdata,   // [31:0] deviation
    output logic                o_m_axis_tuser    // [0] valid_res
);

    localparam int AW        = $clog2(MAX_WINDOW);
    localparam int WW        = $clog2(MAX_WINDOW + 1);
    localparam int SW        = SAMPLE_W + 1 + AW;
    localparam int HW        = SW - SAMPLE_W;
    localparam int QW        = 2 * SAMPLE_W + AW;
    localparam int NW        = QW + WW;
    localparam int BW        = 2 * SW;
    localparam int DW        = 2 * WW;
    localparam int NWP       = NW + (NW % 2);
    localparam int DIV_STEPS = NWP / 2;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int RW        = 64;

    t_state r_state, n_state;

    logic [WIN_W-1:0]        r_cfg_win;
    logic [AW-1:0]           r_wp;
    logic [WW-1:0]           r_fill;
    logic [WW-1:0]           n_fill;
    logic [WW-1:0]           w_eff;
    logic [WW-1:0]           r_win;
    logic [AW-1:0]           r_rptr;
    logic [WW-1:0]           r_iss;
    logic                    r_v1;
    logic                    r_v2;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [2*SAMPLE_W-1:0]   r_sq;
    logic signed [SW-1:0]    r_sum;
    logic [QW-1:0]           r_sumsq;
    logic [63:0]             r_pll;
    logic [HW+SAMPLE_W-1:0]  r_phl;
    logic [2*HW-1:0]         r_phh;
    logic [NW-1:0]           r_a;
    logic [DW-1:0]           r_div;
    logic [DW-1:0]           r_rem;
    logic [NWP-1:0]          r_dn;
    logic [DCW-1:0]          r_dcnt;
    logic [RW-1:0]           r_sn;
    logic [RW-1:0]           r_root;
    logic [RW-1:0]           r_bit;
    logic [DEV_W-1:0]        r_res_dev;
    logic                    r_res_ok;
    logic                    r_out_valid;
    logic [DEV_W-1:0]        r_out_data;
    logic                    r_out_user;

    logic                    in_acc;
    logic                    issue;
    logic                    acc_done;
    logic                    out_load;
    logic [SAMPLE_W-1:0]     ram_q;
    logic signed [SAMPLE_W-1:0] ram_q_s;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [SW-1:0]           mag;
    logic [BW-1:0]           b_full;
    logic [NW-1:0]           num;
    logic [DW-1:0]           div_rem;
    logic [NWP-1:0]          div_dn;
    logic [DW:0]             div_t;
    logic [RW-1:0]           sq_try;

    // ------------------------------------------------------------------
    // ring memory
    // ------------------------------------------------------------------
    swsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_rptr),
        .o_rdata (ram_q)
    );

    assign ram_q_s = $signed(ram_q);
    assign sq_full = ram_q_s * ram_q_s;

    // ------------------------------------------------------------------
    // window clamp and fill count
    // ------------------------------------------------------------------
    always_comb begin
        if (int'(r_cfg_win) < WIN_MIN) begin
            w_eff = WW'(WIN_MIN);
        end else if (int'(r_cfg_win) > MAX_WINDOW) begin
            w_eff = WW'(MAX_WINDOW);
        end else begin
            w_eff = WW'(r_cfg_win);
        end
    end

    always_comb begin
        if (i_s_axis_tuser) begin
            n_fill = WW'(1);
        end else if (r_fill < WW'(MAX_WINDOW)) begin
            n_fill = r_fill + WW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign mag    = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign b_full = BW'(r_pll) + (BW'(r_phl) << (SAMPLE_W + 1))
                  + (BW'(r_phh) << (2 * SAMPLE_W));
    assign num    = r_a - b_full[NW-1:0];
    assign sq_try = r_root + r_bit;

    // two restoring division steps per cycle
    always_comb begin
        div_rem = r_rem;
        div_dn  = r_dn;
        div_t   = '0;
        for (int i = 0; i < 2; i++) begin
            div_t  = {div_rem, div_dn[NWP-1]};
            div_dn = div_dn << 1;
            if (div_t >= {1'b0, r_div}) begin
                div_t     = div_t - {1'b0, r_div};
                div_dn[0] = 1'b1;
            end
            div_rem = div_t[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        acc_done        = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_s_axis_tready = i_rst_n;
                if (i_s_axis_tvalid) begin
                    n_state = (n_fill < w_eff) ? S_OUT : S_ACC;
                end
            end
            S_ACC: begin
                issue    = (r_iss != r_win);
                acc_done = !issue && !r_v1 && !r_v2;
                if (acc_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dcnt == DCW'(DIV_STEPS - 1)) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit[0]) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign in_acc = o_s_axis_tready && i_s_axis_tvalid;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win   <= WIN_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_win <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_wp   <= (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + AW'(1);
                r_fill <= n_fill;
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
            end else if (r_state == S_ACC) begin
                r_v1 <= issue;
                r_v2 <= r_v1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_win   <= w_eff;
                r_rptr  <= r_wp;
                r_iss   <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                // partial window gives the empty result
                r_res_dev <= '0;
                r_res_ok  <= 1'b0;
            end
            S_ACC: begin
                if (issue) begin
                    r_rptr <= (r_rptr == '0) ? AW'(MAX_WINDOW - 1) : r_rptr - AW'(1);
                    r_iss  <= r_iss + WW'(1);
                end
                if (r_v1) begin
                    r_x  <= ram_q_s;
                    r_sq <= sq_full;
                end
                if (r_v2) begin
                    r_sum   <= r_sum + SW'(r_x);
                    r_sumsq <= r_sumsq + QW'(r_sq);
                end
            end
            S_MUL: begin
                r_pll <= 64'(mag[SAMPLE_W-1:0]) * 64'(mag[SAMPLE_W-1:0]);
                r_phl <= (HW + SAMPLE_W)'(mag[SW-1:SAMPLE_W])
                       * (HW + SAMPLE_W)'(mag[SAMPLE_W-1:0]);
                r_phh <= (2 * HW)'(mag[SW-1:SAMPLE_W]) * (2 * HW)'(mag[SW-1:SAMPLE_W]);
                r_a   <= NW'(r_win) * NW'(r_sumsq);
                r_div <= DW'(r_win) * DW'(r_win - WW'(1));
            end
            S_SUB: begin
                r_dn   <= NWP'(num);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_dn   <= div_dn;
                r_rem  <= div_rem;
                r_dcnt <= r_dcnt + DCW'(1);
                // quotient is complete after the last step
                r_sn   <= div_dn[RW-1:0];
                r_root <= '0;
                r_bit  <= RW'(1) << (RW - 2);
            end
            S_SQRT: begin
                if (r_sn >= sq_try) begin
                    r_sn   <= r_sn - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_res_dev <= (r_sn >= sq_try) ? DEV_W'((r_root >> 1) + r_bit)
                                                  : DEV_W'(r_root >> 1);
                    r_res_ok  <= 1'b1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_data <= r_res_dev;
                    r_out_user <= r_res_ok;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTH
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("result without full window carries nonzero deviation");

    a_partial_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (n_fill < w_eff) |=> r_state == S_OUT)
        else $error("partial window word did not go straight to output");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WW'(MAX_WINDOW))
        else $error("fill count beyond ring depth");

    a_iss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |-> r_iss <= r_win)
        else $error("more ring reads issued than the window holds");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_div)
        else $error("divider remainder not below divisor");
`endif

endmodule
